/* rtl/sacl_pkg.sv */
`timescale 1ns / 1ps
// shared command and status types for the cache tag store controller and datapath
package sacl_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;   // write one cleared row of flags and ages
    logic rd;       // request accepted: capture it and read its set
    logic commit;   // write the set back and load the result register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last; // clearing pass is at its last row
  } dp_status_t;

endpackage

/* rtl/sacl_ctrl.sv */
`timescale 1ns / 1ps
// controller: clearing pass, lookup sequencing and output handshake
module sacl_ctrl import sacl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output ctrl_cmd_t  cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  // handshake decode
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !(out_valid_r && out_stall);

  // commands
  always_comb begin
    cmd        = '0;
    cmd.clr_wr = (state_r == ST_CLEAR);
    cmd.rd     = accept;
    cmd.commit = (state_r == ST_LOOKUP) && out_free;
  end

  // next state and next output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/sacl_dp.sv */
`timescale 1ns / 1ps
// datapath: tag and flag memories, hit and victim selection, age update
module sacl_dp import sacl_pkg::*; #(
  parameter int LINE_BYTES = 128,
  parameter int WAYS       = 4,
  parameter int NUM_SETS   = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic        in_is_write,
  input  logic [31:0] in_address,
  output logic        out_hit,
  output logic        out_dirty_writeback
);

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int IDX_BITS = $clog2(NUM_SETS);
  localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W    = $clog2(WAYS + 1);
  localparam int AW_EFF   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int TAG_SH   = OFF_BITS + IDX_BITS;
  localparam int TAG_RAW  = AW_EFF - TAG_SH;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int META_W   = WAYS * (2 + AGE_W);
  localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [AGE_W-1:0] AGE_LIM = AGE_W'(WAYS);

  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][AGE_W-1:0] age;
  } meta_row_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

  // memories: one row per set
  tag_row_t         tag_mem  [NUM_SETS];
  logic [META_W-1:0] meta_mem [NUM_SETS];

  logic [SET_W-1:0] clr_cnt_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic             wr_r;
  tag_row_t         tag_rd_r;
  meta_row_t        meta_rd;
  logic [META_W-1:0] meta_rd_r;
  logic             out_hit_r;
  logic             out_wb_r;

  logic [31:0]      addr_m;
  logic [31:0]      addr_sh;
  logic [31:0]      addr_tg;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  is_vic;
  logic             hit;
  logic             inv_any;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] vic_way;
  logic [WAY_W-1:0] way;
  logic             wb;
  logic [AGE_W-1:0] old_age;
  meta_row_t        meta_new;
  tag_row_t         tag_new;

  // address split of the incoming request
  always_comb begin
    addr_m  = in_address & AMASK;
    addr_sh = addr_m >> OFF_BITS;
    addr_tg = addr_m >> TAG_SH;
    set_in  = (IDX_BITS > 0) ? addr_sh[SET_W-1:0] : '0;
    tag_in  = addr_tg[TAG_W-1:0];
  end

  // clearing pass row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  assign status.clr_last = (clr_cnt_r == SET_W'(NUM_SETS - 1));

  // capture request and read the set
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      set_r     <= set_in;
      tag_r     <= tag_in;
      wr_r      <= in_is_write;
      tag_rd_r  <= tag_mem[set_in];
      meta_rd_r <= meta_mem[set_in];
    end
  end

  assign meta_rd = meta_row_t'(meta_rd_r);

  // tag compare, lowest matching valid way
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = meta_rd.valid[w] && (tag_rd_r[w] == tag_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    hit = |match;
  end

  // highest-numbered invalid way
  always_comb begin
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!meta_rd.valid[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    inv_any = !(&meta_rd.valid);
  end

  // victim: lowest-numbered way with the largest age, pairwise compares
  always_comb begin
    vic_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      is_vic[w] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (j < w && !(meta_rd.age[j] < meta_rd.age[w])) begin
          is_vic[w] = 1'b0;
        end
        if (j > w && !(meta_rd.age[j] <= meta_rd.age[w])) begin
          is_vic[w] = 1'b0;
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (is_vic[w]) begin
        vic_way = WAY_W'(w);
      end
    end
  end

  // updated row of tags, flags and ages
  always_comb begin
    way      = hit ? hit_way : (inv_any ? inv_way : vic_way);
    wb       = !hit && !inv_any && meta_rd.dirty[vic_way];
    old_age  = meta_rd.age[way];
    meta_new = meta_rd;
    tag_new  = tag_rd_r;
    meta_new.valid[way] = 1'b1;
    if (hit) begin
      meta_new.dirty[way] = meta_rd.dirty[way] | wr_r;
    end else begin
      meta_new.dirty[way] = wr_r;
      tag_new[way]        = tag_r;
    end
    for (int w = 0; w < WAYS; w++) begin
      if (meta_rd.age[w] <= old_age && meta_rd.age[w] < AGE_LIM) begin
        meta_new.age[w] = meta_rd.age[w] + AGE_W'(1);
      end
    end
    meta_new.age[way] = '0;
  end

  // flag and age memory: cleared after reset, written back on commit
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      meta_mem[clr_cnt_r] <= '0;
    end else if (cmd.commit) begin
      meta_mem[set_r] <= META_W'(meta_new);
    end
  end

  // tag memory write back
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tag_mem[set_r] <= tag_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r <= hit;
      out_wb_r  <= wb;
    end
  end

  assign out_hit             = out_hit_r;
  assign out_dirty_writeback = out_wb_r;

endmodule

/* rtl/set_assoc_cache_tag_lru.sv */
`timescale 1ns / 1ps
// top level of the write-back set-associative cache tag store with age lru
// Tag store of a write-back set-associative cache. Each request carries a
// read/write flag and a byte address; the block answers with hit and, on a
// miss that evicts a dirty line, dirty_writeback. A request reads the set's
// row of tags, valid and dirty flags and ages from the set memories into
// registers, then picks the way and writes the row back once the output
// register is free; no new request is taken until then. A finished result
// waits in an output register while the next request is taken. After reset
// a clearing pass zeroes the flag and age memory one set per cycle, with
// in_stall high throughout. LINE_BYTES and NUM_SETS must be powers of two.
module set_assoc_cache_tag_lru import sacl_pkg::*; #(
  parameter int LINE_BYTES = 128,
  parameter int WAYS       = 4,
  parameter int NUM_SETS   = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_is_write,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic        out_dirty_writeback
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing and handshake
  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // memories and lookup logic
  sacl_dp #(
    .LINE_BYTES (LINE_BYTES),
    .WAYS       (WAYS),
    .NUM_SETS   (NUM_SETS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_is_write         (in_is_write),
    .in_address          (in_address),
    .out_hit             (out_hit),
    .out_dirty_writeback (out_dirty_writeback)
  );

endmodule

/* rtl/sacl_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the cache tag store, bound to the top level
module sacl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit,
  input logic out_dirty_writeback
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hit) && $stable(out_dirty_writeback))
    else $error("result fields changed while stalled");

  // a hit never reports a writeback
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_dirty_writeback))
    else $error("writeback reported on a hit");

  // the set is busy for the cycle after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous lookup in flight");

endmodule

bind set_assoc_cache_tag_lru sacl_checker u_sacl_checker (.*);
